/* hdl/hhpid_pkg.sv */
package hhpid_pkg;

  localparam int unsigned HeadW = 32;
  localparam int unsigned DriveW = 16;
  localparam int unsigned GainW = 24;
  localparam int unsigned MaxW = 15;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned SpeedW = 24;

  localparam logic [CfgIdxW-1:0] RegTarget = 3'd0;
  localparam logic [CfgIdxW-1:0] RegBase = 3'd1;
  localparam logic [CfgIdxW-1:0] RegGainP = 3'd2;
  localparam logic [CfgIdxW-1:0] RegGainI = 3'd3;
  localparam logic [CfgIdxW-1:0] RegGainD = 3'd4;
  localparam logic [CfgIdxW-1:0] RegMax = 3'd5;

  localparam logic [GainW-1:0] GainPReset = 24'd393216;
  localparam logic [GainW-1:0] GainDReset = 24'd1966080;
  localparam logic [MaxW-1:0] MaxReset = 15'd25600;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SUM,
    S_LIM,
    S_DIV,
    S_OUT
  } state_t;

  typedef struct packed {
    logic signed [HeadW-1:0] heading;
    logic start_move;
  } in_item_t;

  typedef struct packed {
    logic signed [DriveW-1:0] left_drive;
    logic signed [DriveW-1:0] right_drive;
    logic signed [HeadW-1:0] heading_error;
    logic was_limited;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [CfgDataW-1:0] data;
  } cfg_item_t;

endpackage

/* hdl/hhpid_if.sv */
interface hhpid_if #(
  parameter type payload_t = logic
);
  logic valid;
  logic ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* hdl/hhpid_div.sv */
// restoring divider, one quotient bit per cycle
module hhpid_div (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [hhpid_pkg::SpeedW+hhpid_pkg::MaxW-1:0] dividend,
  input  logic [hhpid_pkg::SpeedW+1:0] divisor,
  output logic done,
  output logic [hhpid_pkg::SpeedW+hhpid_pkg::MaxW-1:0] quotient
);
  import hhpid_pkg::*;
  localparam int unsigned NW = SpeedW + MaxW;
  localparam int unsigned DW = SpeedW + 2;

  logic [NW-1:0] q;
  logic [DW:0] rem;
  logic [DW-1:0] den;
  logic [$clog2(NW+1)-1:0] cnt;
  logic busy;
  logic [DW:0] trial;
  logic [DW:0] shifted;

  assign shifted = {rem[DW-1:0], q[NW-1]};
  assign trial = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= ($clog2(NW+1))'(NW);
      end else if (busy) begin
        cnt <= cnt - ($clog2(NW+1))'(1);
        if (cnt == ($clog2(NW+1))'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= dividend;
      rem <= '0;
      den <= divisor;
    end else if (busy) begin
      if (!trial[DW]) begin
        rem <= trial;
        q <= {q[NW-2:0], 1'b1};
      end else begin
        rem <= shifted;
        q <= {q[NW-2:0], 1'b0};
      end
    end
  end

  assign quotient = q;
endmodule

/* hdl/heading_hold_pid_differential_drive_unit.sv */
// steps: input transfer, bit-serial multiply, sum, limit check, then output; when
//   the outputs are scaled, two serial divisions come before the output
// throughput: one item at a time, the next input transfer only after the last
//   result is loaded; a result still waiting in the output register holds the
//   following item only at its final step
// reset: synchronous rst restores gains, max speed, clears error state
module heading_hold_pid_differential_drive_unit #(
  parameter int unsigned SUM_WIDTH = 40
) (
  input  logic clk,
  input  logic rst,
  hhpid_if.sink   in_ch,
  hhpid_if.source out_ch,
  hhpid_if.sink   cfg
);
  import hhpid_pkg::*;

  localparam int unsigned AW = SUM_WIDTH + GainW + 2;
  localparam int unsigned NW = SpeedW + MaxW;

  logic signed [HeadW-1:0] target_heading;
  logic signed [DriveW-1:0] base_speed;
  logic [GainW-1:0] gain_p, gain_i, gain_d;
  logic [MaxW-1:0] max_speed;

  logic signed [HeadW-1:0] last_error;
  logic signed [SUM_WIDTH-1:0] error_sum;

  state_t state, state_next;
  logic signed [HeadW-1:0] err;
  logic signed [HeadW:0] derr;
  logic signed [SUM_WIDTH-1:0] sum_use;
  logic [GainW-1:0] mp, mi, md;
  logic [4:0] bitcnt;
  logic signed [AW-1:0] acc;
  logic signed [SpeedW-1:0] speed;
  logic signed [SpeedW+1:0] vl, vr;
  logic [SpeedW+1:0] mag_l, mag_r, m;
  logic side;
  logic lim;
  logic div_start, div_done;
  logic [NW-1:0] div_q;
  logic [NW-1:0] dividend;
  logic signed [DriveW-1:0] left_r, right_r;
  out_item_t res;
  logic res_valid;
  logic out_load;

  logic signed [HeadW:0] ediff;
  logic signed [HeadW-1:0] e_in;
  logic signed [AW-1:0] addend;
  logic signed [AW-1:0] fl;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_heading <= '0;
      base_speed <= '0;
      gain_p <= GainPReset;
      gain_i <= '0;
      gain_d <= GainDReset;
      max_speed <= MaxReset;
    end else if (cfg.valid) begin
      case (cfg.payload.index)
        RegTarget: target_heading <= cfg.payload.data;
        RegBase: base_speed <= cfg.payload.data[DriveW-1:0];
        RegGainP: gain_p <= cfg.payload.data[GainW-1:0];
        RegGainI: gain_i <= cfg.payload.data[GainW-1:0];
        RegGainD: gain_d <= cfg.payload.data[GainW-1:0];
        RegMax: max_speed <= cfg.payload.data[MaxW-1:0];
        default: ;
      endcase
    end
  end

  assign ediff = {target_heading[HeadW-1], target_heading}
               - {in_ch.payload.heading[HeadW-1], in_ch.payload.heading};
  assign e_in = (ediff[HeadW] != ediff[HeadW-1])
              ? {ediff[HeadW], {(HeadW-1){!ediff[HeadW]}}} : ediff[HeadW-1:0];

  assign in_ch.ready = (state == S_IDLE);
  assign out_load = (state == S_OUT) && (!res_valid || out_ch.ready);

  // shift-and-add, one bit of each gain per cycle, msb first
  always_comb begin
    addend = '0;
    if (mp[GainW-1]) addend = addend + AW'(err);
    if (mi[GainW-1]) addend = addend + AW'(sum_use);
    if (md[GainW-1]) addend = addend + AW'(derr);
  end

  assign fl = acc >>> 16;
  assign mag_l = vl[SpeedW+1] ? -vl : vl;
  assign mag_r = vr[SpeedW+1] ? -vr : vr;
  assign dividend = NW'(side ? mag_r[NW-MaxW-1:0] : mag_l[NW-MaxW-1:0])
                  * NW'(max_speed);
  assign div_start = (state == S_DIV) && (bitcnt == 5'd0);

  hhpid_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(dividend),
    .divisor(m), .done(div_done), .quotient(div_q)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_ch.valid && in_ch.ready) state_next = S_MUL;
      S_MUL: if (bitcnt == 5'(GainW-1)) state_next = S_SUM;
      S_SUM: state_next = S_LIM;
      S_LIM: state_next = lim ? S_DIV : S_OUT;
      S_DIV: if (div_done && side) state_next = S_OUT;
      S_OUT: if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_error <= '0;
      error_sum <= '0;
      res_valid <= 1'b0;
      bitcnt <= '0;
      side <= 1'b0;
    end else begin
      if (out_load) res_valid <= 1'b1;
      else if (out_ch.valid && out_ch.ready) res_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          err <= e_in;
          sum_use <= in_ch.payload.start_move ? '0 : error_sum;
          derr <= in_ch.payload.start_move ? '0
                : {e_in[HeadW-1], e_in} - {last_error[HeadW-1], last_error};
          if (in_ch.payload.start_move) last_error <= e_in;
          if (in_ch.payload.start_move) error_sum <= '0;
          mp <= gain_p;
          mi <= gain_i;
          md <= gain_d;
          acc <= '0;
          bitcnt <= '0;
        end
        S_MUL: begin
          acc <= (acc <<< 1) + addend;
          mp <= mp << 1;
          mi <= mi << 1;
          md <= md << 1;
          bitcnt <= bitcnt + 5'd1;
        end
        S_SUM: begin
          speed <= (fl > $signed(AW'(23'h7fffff))) ? SpeedW'(24'h7fffff)
                 : (fl < -$signed(AW'(24'h800000))) ? SpeedW'(24'h800000)
                 : fl[SpeedW-1:0];
          bitcnt <= '0;
          side <= 1'b0;
        end
        S_DIV: begin
          if (div_done && !side) begin
            left_r <= vl[SpeedW+1] ? -DriveW'(div_q) : DriveW'(div_q);
            side <= 1'b1;
            bitcnt <= 5'd0;
          end else begin
            bitcnt <= 5'd1;
            if (div_done) right_r <= vr[SpeedW+1] ? -DriveW'(div_q) : DriveW'(div_q);
          end
        end
        S_OUT: if (out_load) begin
          res.left_drive <= lim ? left_r : vl[DriveW-1:0];
          res.right_drive <= lim ? right_r : vr[DriveW-1:0];
          res.heading_error <= err;
          res.was_limited <= lim;
          last_error <= err;
          if (err == '0 || last_error == '0 || (err[HeadW-1] != last_error[HeadW-1]))
            error_sum <= '0;
          else if (!err[HeadW-1])
            error_sum <= (sum_use > (signed'({1'b0, {(SUM_WIDTH-1){1'b1}}}) - SUM_WIDTH'(err)))
                       ? {1'b0, {(SUM_WIDTH-1){1'b1}}} : sum_use + SUM_WIDTH'(err);
          else
            error_sum <= (sum_use < (signed'({1'b1, {(SUM_WIDTH-1){1'b0}}}) - SUM_WIDTH'(err)))
                       ? {1'b1, {(SUM_WIDTH-1){1'b0}}} : sum_use + SUM_WIDTH'(err);
        end
        default: ;
      endcase
    end
  end

  assign vl = (SpeedW+2)'(base_speed) + (SpeedW+2)'(speed);
  assign vr = (SpeedW+2)'(base_speed) - (SpeedW+2)'(speed);
  assign m = (mag_l > mag_r) ? mag_l : mag_r;
  assign lim = m > (SpeedW+2)'(max_speed);

  assign out_ch.valid = res_valid;
  assign out_ch.payload = res;
endmodule

/* hdl/hhpid_checker.sv */
module hhpid_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);
  a_ready_after_reset: assert property (@(posedge clk)
    rst |=> in_ready) else $error("input not ready after reset");
  a_no_result_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid) else $error("result after reset");
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready) else $error("double accept");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
endmodule

bind heading_hold_pid_differential_drive_unit hhpid_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready)
);

/* tb/tb_heading_hold_pid_differential_drive_unit.sv */
module tb_heading_hold_pid_differential_drive_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import hhpid_pkg::*;

  localparam int SumW = 40;
  localparam longint CycleLimit = 1500000;
  localparam int SettleCycles = 140;
  localparam logic [CfgIdxW-1:0] RegUnused6 = 3'd6;
  localparam logic [CfgIdxW-1:0] RegUnused7 = 3'd7;

  logic clk;
  logic rst;

  hhpid_if #(.payload_t(in_item_t)) in_ch ();
  hhpid_if #(.payload_t(out_item_t)) out_ch ();
  hhpid_if #(.payload_t(cfg_item_t)) cfg_ch ();

  heading_hold_pid_differential_drive_unit #(.SUM_WIDTH(SumW)) u_top (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg(cfg_ch)
  );

  // controller state mirrored by the predictor
  longint target_hd, base_spd, kp, ki, kd, max_spd;
  longint last_err, err_sum;

  out_item_t drive_q[$];
  int mismatches;
  int failures;
  int sent_items;
  int checked_results;
  int limited_seen;
  int burst_left;
  longint cycles;
  bit hold_req;
  int hold_cnt;
  int rx_mode;
  int rx_mode_left;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void reset_controller();
    target_hd = 0;
    base_spd = 0;
    kp = 393216;
    ki = 0;
    kd = 1966080;
    max_spd = 25600;
    last_err = 0;
    err_sum = 0;
  endfunction

  function automatic void apply_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    case (idx)
      RegTarget: target_hd = longint'($signed(data[31:0]));
      RegBase: base_spd = longint'($signed(data[15:0]));
      RegGainP: kp = longint'({40'd0, data[23:0]});
      RegGainI: ki = longint'({40'd0, data[23:0]});
      RegGainD: kd = longint'({40'd0, data[23:0]});
      RegMax: max_spd = longint'({49'd0, data[14:0]});
      default: ;
    endcase
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint magn(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic out_item_t predict_drive(in_item_t it);
    longint hd, e, hi, lo, kih, lim, acc, spd, vl, vr, m, smax, smin, big;
    bit limited;
    out_item_t r;
    smax = (longint'(1) <<< (SumW - 1)) - 1;
    smin = -smax - 1;
    big = longint'(1) <<< 42;
    limited = 1'b0;
    hd = longint'(it.heading);
    e = clip(target_hd - hd, -64'sd2147483648, 64'sd2147483647);
    if (it.start_move) begin
      last_err = e;
      err_sum = 0;
    end
    hi = err_sum >>> 16;
    lo = err_sum & 64'hFFFF;
    if (ki == 0) begin
      kih = 0;
    end else begin
      lim = big / ki;
      if (hi > lim) kih = big;
      else if (hi < -lim) kih = -big;
      else kih = ki * hi;
    end
    acc = kp * e + kd * (e - last_err) + ki * lo + kih * 65536;
    spd = clip(acc >>> 16, -(longint'(1) <<< 23), (longint'(1) <<< 23) - 1);
    vl = base_spd + spd;
    vr = base_spd - spd;
    m = magn(vl) > magn(vr) ? magn(vl) : magn(vr);
    if (m > max_spd) begin
      vl = vl < 0 ? -((magn(vl) * max_spd) / m) : (magn(vl) * max_spd) / m;
      vr = vr < 0 ? -((magn(vr) * max_spd) / m) : (magn(vr) * max_spd) / m;
      limited = 1'b1;
    end
    if (e == 0 || last_err == 0 || ((e < 0) != (last_err < 0))) err_sum = 0;
    else if (e > 0) err_sum = (err_sum > smax - e) ? smax : err_sum + e;
    else err_sum = (err_sum < smin - e) ? smin : err_sum + e;
    last_err = e;
    r.left_drive = vl[15:0];
    r.right_drive = vr[15:0];
    r.heading_error = e[31:0];
    r.was_limited = limited;
    return r;
  endfunction

  // transfers on all three channels, seen at the rising edge
  always @(posedge clk) begin
    out_item_t exp_r, got;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) apply_reg(cfg_ch.payload.index, cfg_ch.payload.data);
      if (in_ch.valid && in_ch.ready) drive_q = {drive_q, predict_drive(in_ch.payload)};
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.payload;
        if (drive_q.size() == 0) begin
          failures++;
          $display("unexpected result: %p", got);
        end else begin
          exp_r = drive_q.pop_front();
          checked_results++;
          if (got.was_limited) limited_seen++;
          if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: expected L=%0d R=%0d E=%0d lim=%0b, ",
                        "got L=%0d R=%0d E=%0d lim=%0b"},
                       exp_r.left_drive, exp_r.right_drive, exp_r.heading_error,
                       exp_r.was_limited, got.left_drive, got.right_drive,
                       got.heading_error, got.was_limited);
          end
        end
      end
    end
  end

  // receiver stall pattern plus long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req <= 1'b0;
      hold_cnt <= 400;
      out_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ch.ready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode <= $urandom_range(0, 3);
        rx_mode_left <= $urandom_range(20, 300);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= $urandom_range(0, 1);
        2: out_ch.ready <= ($urandom_range(0, 7) == 0);
        default: out_ch.ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  task automatic send_item(input logic signed [31:0] hd, input bit st);
    int gap;
    in_item_t it;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      repeat (gap) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
      end
    end
    burst_left--;
    it.heading = hd;
    it.start_move = st;
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.payload <= it;
    do @(posedge clk); while (!in_ch.ready);
    sent_items++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_item_t c;
    c.index = idx;
    c.data = data;
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.payload <= c;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic write_all(input logic [31:0] tgt, input logic [31:0] base,
                           input logic [31:0] gp, input logic [31:0] gi,
                           input logic [31:0] gd, input logic [31:0] mx);
    write_reg(RegTarget, tgt);
    write_reg(RegBase, base);
    write_reg(RegGainP, gp);
    write_reg(RegGainI, gi);
    write_reg(RegGainD, gd);
    write_reg(RegMax, mx);
  endtask

  task automatic test_reset_values();
    send_item(32'sd0, 1'b1);
    send_item(32'sd256, 1'b0);
    send_item(-32'sd512, 1'b0);
    send_item(32'sd1, 1'b0);
    send_item(32'sd0, 1'b0);
    wait_idle();
  endtask

  task automatic test_directed();
    write_all(32'h7FFF_FFFF, 32'hABCD_6400, 32'hFF_FFFF, 32'hFF_FFFF, 32'hFF_FFFF, 32'h7FFF);
    send_item(32'h8000_0000, 1'b1);
    send_item(32'h7FFF_FFFF, 1'b0);
    send_item(32'h7FFF_FFFF, 1'b1);
    send_item(32'sd0, 1'b0);
    wait_idle();
    write_all(32'h8000_0000, 32'h0000_8000, 32'd0, 32'd0, 32'd0, 32'd1);
    send_item(32'h7FFF_FFFF, 1'b1);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'sd0, 1'b0);
    wait_idle();
    // zero limit: moving commands collapse to zero, still ones pass unlimited
    write_all(32'sd1000, 32'sd0, 32'd65536, 32'd0, 32'd0, 32'd0);
    send_item(32'sd1000, 1'b1);
    send_item(32'sd900, 1'b0);
    send_item(32'sd1000, 1'b0);
    wait_idle();
    write_reg(RegBase, 32'h0000_7FFF);
    write_reg(RegMax, 32'hFFFF_0000);
    send_item(32'sd1000, 1'b0);
    wait_idle();
    // out-of-range base speeds with a wide limit
    write_all(32'sd0, 32'h0000_7FFF, 32'd1, 32'd0, 32'd0, 32'h7FFF);
    send_item(32'sd0, 1'b1);
    send_item(-32'sd100, 1'b0);
    wait_idle();
    write_reg(RegBase, 32'hFFFF_8000);
    write_reg(RegUnused6, 32'hFFFF_FFFF);
    write_reg(RegUnused7, 32'h1234_5678);
    send_item(32'sd100, 1'b1);
    send_item(32'sd0, 1'b0);
    send_item(32'sd50, 1'b0);
    send_item(-32'sd50, 1'b0);
    send_item(-32'sd60, 1'b0);
    send_item(-32'sd70, 1'b0);
    wait_idle();
  endtask

  task automatic test_integral_saturation();
    write_all(32'sd0, 32'sd0, 32'd0, 32'hFF_FFFF, 32'd0, 32'd25600);
    send_item(32'h8000_0000, 1'b1);
    repeat (261) send_item(32'h8000_0000, 1'b0);
    wait_idle();
    write_all(32'h8000_0000, 32'sd1000, 32'd0, 32'd1, 32'd0, 32'd20000);
    send_item(32'h7FFF_FFFF, 1'b1);
    repeat (261) send_item(32'h7FFF_FFFF, 1'b0);
    wait_idle();
  endtask

  task automatic random_config();
    logic [31:0] tgt, gp, gi, gd, mx, base;
    tgt = ($urandom_range(0, 1) == 0) ? $urandom : 32'($signed($urandom_range(0, 20000)) - 10000);
    base = ($urandom_range(0, 5) == 0) ? $urandom
           : {16'($urandom_range(0, 65535)),
              16'($signed($urandom_range(0, 51200)) - 25600)};
    gp = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 131072);
    gi = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 4000);
    gd = ($urandom_range(0, 2) == 0) ? $urandom : $urandom_range(0, 131072);
    case ($urandom_range(0, 4))
      0: mx = $urandom;
      1: mx = 32'd25600;
      2: mx = $urandom_range(0, 3);
      default: mx = $urandom_range(1, 25600);
    endcase
    write_all(tgt, base, gp, gi, gd, mx);
  endtask

  task automatic test_random();
    logic signed [31:0] hd;
    int n;
    for (int ph = 0; ph < 6; ph++) begin
      random_config();
      n = 0;
      while (n < 75) begin
        if ($urandom_range(0, 4) == 0) begin
          send_item($urandom, 1'($urandom_range(0, 1)));
          n++;
        end else begin
          hd = 32'(target_hd + $signed($urandom_range(0, 4000)) - 2000);
          send_item(hd, 1'b1);
          n++;
          repeat ($urandom_range(3, 20)) begin
            hd = hd + $signed($urandom_range(0, 600)) - 300;
            send_item(hd, 1'b0);
            n++;
          end
        end
      end
      wait_idle();
    end
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    burst_left = 40;
    send_item(32'sd10, 1'b1);
    repeat (39) send_item($urandom, 1'b0);
    wait_idle();
  endtask

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.payload = '0;
    out_ch.ready = 1'b0;
    hold_req = 1'b0;
    hold_cnt = 0;
    rx_mode = 0;
    rx_mode_left = 0;
    cycles = 0;
    mismatches = 0;
    failures = 0;
    sent_items = 0;
    checked_results = 0;
    limited_seen = 0;
    burst_left = 0;
    reset_controller();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_directed();
    test_integral_saturation();
    test_random();
    test_backpressure();
    wait_idle();
    if (drive_q.size() != 0) failures++;
    $display("%0d headings sent, %0d drive results checked, %0d scaled to the limit",
             sent_items, checked_results, limited_seen);
    $display("%0d mismatches, %0d other failures", mismatches, failures);
    if (mismatches == 0 && failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
